@@ src/sps_pkg.sv @@
// shared types and constants of the stack permutation sequencer
package sps_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned VALUE_WIDTH = 16;
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);

  // input operation codes
  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_TARGET = 2'd1,
    OP_FINISH = 2'd2
  } op_e;

  // result action codes
  typedef enum logic [2:0] {
    ACT_DEQUEUE    = 3'd0,
    ACT_PUSH       = 3'd1,
    ACT_POP        = 3'd2,
    ACT_ENQUEUE    = 3'd3,
    ACT_POSSIBLE   = 3'd4,
    ACT_IMPOSSIBLE = 3'd5
  } action_e;

  // what a storage cell takes in this cycle
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_PREV = 2'd1,
    CELL_NEXT = 2'd2,
    CELL_EXT  = 2'd3
  } cell_op_e;

endpackage

@@ src/sps_in_if.sv @@
// input channel: operation and value with valid/ready
interface sps_in_if;
  import sps_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [1:0]             operation;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

@@ src/sps_out_if.sv @@
// output channel: action and last with valid/ready
interface sps_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic       last;

  modport source (output valid, output action, output last, input ready);
  modport sink   (input valid, input action, input last, output ready);
endinterface

@@ src/stack_permutation_sequencer.sv @@
// top level of the stack permutation sequencer
//
// loads go into a queue built as a chain of DEPTH cells whose head is cell 0;
// a dequeue shifts every cell one place toward the head. the side stack is a
// second chain with its top in cell 0; push shifts away from the top, pop
// shifts toward it. a load emits nothing; loads after DEPTH since the last
// finish are dropped. a target whose value sits on the stack top emits pop,
// enqueue. otherwise it walks the queue one action per cycle unless the
// output stalls, emitting dequeue then enqueue (match) or push (no match).
// a target with no stack top match and an empty queue emits nothing. finish
// emits one verdict (possible when the stack is empty) and clears both
// chains. one item is worked on at a time; the next is taken once the last
// action of the current one has entered the output register.
module stack_permutation_sequencer (
  input  logic      clk_i,
  input  logic      rst_ni,
  sps_in_if.sink    in_i,
  sps_out_if.source out_o
);
  import sps_pkg::*;

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DEQ  = 4'b0010,
    S_ENQ  = 4'b0100,
    S_PUSH = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       qcnt_q, qcnt_d;   // pending queue entries
  logic [CNT_W-1:0]       tail_q, tail_d;   // loads since last clear
  logic [CNT_W-1:0]       scnt_q, scnt_d;   // stack fill
  logic [VALUE_WIDTH-1:0] key_q, key_d;
  logic                   ov_q, ov_d;
  action_e                act_q, act_d;
  logic                   last_q, last_d;

  logic                   out_free;
  logic                   in_fire;
  logic                   q_load, q_shift, s_push, s_pop;

  cell_op_e               q_op   [DEPTH];
  cell_op_e               s_op   [DEPTH];
  logic [VALUE_WIDTH-1:0] q_data [DEPTH];
  logic [VALUE_WIDTH-1:0] s_data [DEPTH];
  logic [VALUE_WIDTH-1:0] front, top;

  assign front    = q_data[0];
  assign top      = s_data[0];
  // output register can take a new action this cycle
  assign out_free = !ov_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && out_free;
  assign in_fire  = in_i.valid && in_i.ready;

  always_comb begin
    state_d = state_q;
    qcnt_d  = qcnt_q;
    tail_d  = tail_q;
    scnt_d  = scnt_q;
    key_d   = key_q;
    ov_d    = ov_q && !out_o.ready;
    act_d   = act_q;
    last_d  = last_q;
    q_load  = 1'b0;
    q_shift = 1'b0;
    s_push  = 1'b0;
    s_pop   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_i.operation)
            OP_LOAD: begin
              if (tail_q < CNT_W'(DEPTH)) begin
                q_load = 1'b1;
                qcnt_d = qcnt_q + CNT_W'(1);
                tail_d = tail_q + CNT_W'(1);
              end
            end
            OP_TARGET: begin
              key_d = in_i.value;
              if ((scnt_q != '0) && (top == in_i.value)) begin
                // match on the stack top: pop then enqueue
                s_pop   = 1'b1;
                scnt_d  = scnt_q - CNT_W'(1);
                ov_d    = 1'b1;
                act_d   = ACT_POP;
                last_d  = 1'b0;
                state_d = S_ENQ;
              end else if (qcnt_q != '0) begin
                state_d = S_DEQ;
              end
            end
            OP_FINISH: begin
              ov_d   = 1'b1;
              act_d  = (scnt_q == '0) ? ACT_POSSIBLE : ACT_IMPOSSIBLE;
              last_d = 1'b1;
              qcnt_d = '0;
              tail_d = '0;
              scnt_d = '0;
            end
            default: ;  // unused code, ignored
          endcase
        end
      end
      S_DEQ: begin
        if (out_free) begin
          q_shift = 1'b1;
          qcnt_d  = qcnt_q - CNT_W'(1);
          ov_d    = 1'b1;
          act_d   = ACT_DEQUEUE;
          last_d  = 1'b0;
          if (front == key_q) begin
            state_d = S_ENQ;
          end else begin
            // no match: value moves onto the stack
            s_push  = 1'b1;
            scnt_d  = scnt_q + CNT_W'(1);
            state_d = S_PUSH;
          end
        end
      end
      S_ENQ: begin
        if (out_free) begin
          ov_d    = 1'b1;
          act_d   = ACT_ENQUEUE;
          last_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          ov_d    = 1'b1;
          act_d   = ACT_PUSH;
          // queue drained: search ends here
          last_d  = (qcnt_q == '0);
          state_d = (qcnt_q == '0) ? S_IDLE : S_DEQ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      qcnt_q  <= '0;
      tail_q  <= '0;
      scnt_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      qcnt_q  <= qcnt_d;
      tail_q  <= tail_d;
      scnt_q  <= scnt_d;
      ov_q    <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    act_q  <= act_d;
    last_q <= last_d;
  end

  assign out_o.valid  = ov_q;
  assign out_o.action = act_q;
  assign out_o.last   = last_q;

  // queue and stack chains
  for (genvar k = 0; k < DEPTH; k++) begin : g_chain
    logic [VALUE_WIDTH-1:0] q_next, s_prev, s_next;

    always_comb begin
      if (q_load && (qcnt_q == CNT_W'(k))) begin
        q_op[k] = CELL_EXT;
      end else if (q_shift) begin
        q_op[k] = CELL_NEXT;
      end else begin
        q_op[k] = CELL_HOLD;
      end
    end

    always_comb begin
      if (s_push) begin
        s_op[k] = (k == 0) ? CELL_EXT : CELL_PREV;
      end else if (s_pop) begin
        s_op[k] = CELL_NEXT;
      end else begin
        s_op[k] = CELL_HOLD;
      end
    end

    if (k == DEPTH - 1) begin : g_end
      assign q_next = '0;
      assign s_next = '0;
    end else begin : g_mid
      assign q_next = q_data[k+1];
      assign s_next = s_data[k+1];
    end

    if (k == 0) begin : g_first
      assign s_prev = '0;
    end else begin : g_rest
      assign s_prev = s_data[k-1];
    end

    sps_cell u_qcell (
      .clk_i  (clk_i),
      .op_i   (q_op[k]),
      .prev_i ('0),
      .next_i (q_next),
      .ext_i  (in_i.value),
      .data_o (q_data[k])
    );

    sps_cell u_scell (
      .clk_i  (clk_i),
      .op_i   (s_op[k]),
      .prev_i (s_prev),
      .next_i (s_next),
      .ext_i  (front),
      .data_o (s_data[k])
    );
  end
endmodule

@@ src/sps_cell.sv @@
// one storage cell of the queue or stack chain
module sps_cell (
  input  logic                            clk_i,
  input  sps_pkg::cell_op_e               op_i,
  input  logic [sps_pkg::VALUE_WIDTH-1:0] prev_i,
  input  logic [sps_pkg::VALUE_WIDTH-1:0] next_i,
  input  logic [sps_pkg::VALUE_WIDTH-1:0] ext_i,
  output logic [sps_pkg::VALUE_WIDTH-1:0] data_o
);
  import sps_pkg::*;

  logic [VALUE_WIDTH-1:0] data_q, data_d;

  always_comb begin
    unique case (op_i)
      CELL_HOLD: data_d = data_q;
      CELL_PREV: data_d = prev_i;
      CELL_NEXT: data_d = next_i;
      CELL_EXT:  data_d = ext_i;
      default:   data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
endmodule

@@ test/tb_stack_permutation_sequencer.sv @@
// testbench of the stack permutation sequencer: random load/target/finish rounds checked per action
module tb_stack_permutation_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import sps_pkg::*;

  // operation code that the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 300;
  // slowest target walks the whole queue, plus margin
  localparam int DRAIN_CYCLES = 4 * DEPTH + 16;
  // worst run: every item stalled by the longest gaps on both sides, taken several times over
  localparam int CYCLE_LIMIT  = 1_000_000;
  // the last stretch of the run goes without any idling
  localparam int CALM_TAIL    = 40;

  typedef struct {
    logic [1:0]             op;
    logic [VALUE_WIDTH-1:0] val;
    bit                     hold; // wait for every pending action before sending
  } request_t;

  typedef struct {
    action_e act;
    logic    last;
  } action_t;

  logic clk_i;
  logic rst_ni;

  sps_in_if  in_if ();
  sps_out_if out_if ();

  stack_permutation_sequencer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // stimulus waiting to be sent and actions waiting to arrive
  request_t pending_items [$];
  action_t  expected_actions [$];

  // shadow of the block: source queue and side stack
  logic [VALUE_WIDTH-1:0] shadow_queue [DEPTH];
  logic [VALUE_WIDTH-1:0] shadow_stack [DEPTH];
  int unsigned            shadow_head;
  int unsigned            shadow_tail;
  int unsigned            shadow_depth;

  int  n_errors;
  int  n_queued;      // items that the block acts on
  int  n_sent;
  int  n_checked;
  int  n_possible;
  int  n_impossible;
  int  n_overflow;
  int  calm_from;
  int  src_gap;
  int  snk_gap;
  int  cycles;
  logic no_idle;

  // ---------------------------------------------------------------------------
  // clock and reset
  // ---------------------------------------------------------------------------
  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor: one accepted item in, the actions it causes appended
  // ---------------------------------------------------------------------------
  function automatic void note_action(action_e a);
    action_t e;
    e.act  = a;
    e.last = 1'b0;
    expected_actions.insert(expected_actions.size(), e);
  endfunction

  function automatic void predict_actions(logic [1:0] op, logic [VALUE_WIDTH-1:0] val);
    int unsigned            before_n;
    logic [VALUE_WIDTH-1:0] front;
    before_n = expected_actions.size();
    case (op)
      OP_LOAD: begin
        // loads past the queue depth are dropped silently
        if (shadow_tail < DEPTH) begin
          shadow_queue[shadow_tail] = val;
          shadow_tail++;
        end else begin
          n_overflow++;
        end
      end
      OP_TARGET: begin
        if (shadow_depth > 0 && shadow_stack[shadow_depth-1] == val) begin
          // the target sits on the stack top
          shadow_depth--;
          note_action(ACT_POP);
          note_action(ACT_ENQUEUE);
        end else begin
          // walk the queue, parking every miss on the stack
          while (shadow_head < shadow_tail) begin
            front = shadow_queue[shadow_head];
            shadow_head++;
            note_action(ACT_DEQUEUE);
            if (front == val) begin
              note_action(ACT_ENQUEUE);
              break;
            end
            shadow_stack[shadow_depth] = front;
            shadow_depth++;
            note_action(ACT_PUSH);
          end
        end
        if (expected_actions.size() > before_n)
          expected_actions[expected_actions.size()-1].last = 1'b1;
      end
      OP_FINISH: begin
        // leftovers in the queue do not matter, only the stack
        if (shadow_depth == 0) note_action(ACT_POSSIBLE);
        else note_action(ACT_IMPOSSIBLE);
        expected_actions[expected_actions.size()-1].last = 1'b1;
        shadow_head  = 0;
        shadow_tail  = 0;
        shadow_depth = 0;
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------
  task automatic queue_item(logic [1:0] op, logic [VALUE_WIDTH-1:0] val, bit hold);
    request_t r;
    r.op   = op;
    r.val  = val;
    r.hold = hold;
    pending_items.insert(pending_items.size(), r);
    if (op != OP_UNUSED) n_queued++;
  endtask

  // one round: loads, a target sequence, mostly a finish
  task automatic queue_round();
    logic [VALUE_WIDTH-1:0] loaded [$];
    logic [VALUE_WIDTH-1:0] order [$];
    logic [VALUE_WIDTH-1:0] parked [$];
    logic [VALUE_WIDTH-1:0] v;
    int                     n_loads;
    int                     idx;
    int                     pick;
    int                     r;
    bit                     narrow;
    r = $urandom_range(0, 19);
    // mostly short rounds, some up to a full queue, a few overflowing it
    if (r < 12) n_loads = $urandom_range(1, 5);
    else if (r < 18) n_loads = $urandom_range(6, DEPTH);
    else n_loads = DEPTH + $urandom_range(1, 3);
    // narrow values give duplicates
    narrow = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n_loads; i++) begin
      v = narrow ? VALUE_WIDTH'($urandom_range(0, 3)) : VALUE_WIDTH'($urandom);
      queue_item(OP_LOAD, v, 1'b0);
      if (i < DEPTH) loaded.insert(loaded.size(), v);
    end
    pick = $urandom_range(0, 9);
    if (pick < 5 || pick == 9) begin
      // order that a stack can produce: random interleave of push and pop
      idx = 0;
      while (order.size() < loaded.size()) begin
        if (parked.size() > 0 && (idx == loaded.size() || $urandom_range(0, 1) == 1)) begin
          order.insert(order.size(), parked.pop_back());
        end else begin
          parked.insert(parked.size(), loaded[idx]);
          idx++;
        end
      end
      // cut short: finish with values still pending
      if (pick == 9)
        while (order.size() > 0 && $urandom_range(0, 2) != 0) void'(order.pop_back());
    end else if (pick < 8) begin
      order = loaded;
      order.shuffle();
    end else begin
      // arbitrary targets, many absent from the queue
      for (int i = 0; i < $urandom_range(1, 4); i++) begin
        if ($urandom_range(0, 1) == 1) order.insert(order.size(), VALUE_WIDTH'($urandom));
        else order.insert(order.size(), loaded[$urandom_range(0, loaded.size() - 1)]);
      end
    end
    foreach (order[i]) begin
      if ($urandom_range(0, 11) == 0) queue_item(OP_UNUSED, VALUE_WIDTH'($urandom), 1'b0);
      queue_item(OP_TARGET, order[i], 1'b0);
    end
    if ($urandom_range(0, 9) != 0)
      queue_item(OP_FINISH, VALUE_WIDTH'($urandom), $urandom_range(0, 15) == 0);
  endtask

  // ---------------------------------------------------------------------------
  // driver: sends pending items, with random bursts of idling
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    request_t cur;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        predict_actions(in_if.operation, in_if.value);
        n_sent++;
        // a quiet stretch in the middle and the whole tail
        no_idle <= (n_sent >= calm_from) || ((n_sent / 50) % 4 == 3);
      end
      if (!in_if.valid || in_if.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_if.valid <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 11) == 0) begin
          src_gap = $urandom_range(0, 18);
          in_if.valid <= 1'b0;
        end else if (pending_items.size() > 0 &&
                     !(pending_items[0].hold && expected_actions.size() != 0)) begin
          cur = pending_items.pop_front();
          in_if.valid     <= 1'b1;
          in_if.operation <= cur.op;
          in_if.value     <= cur.val;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each action transfer, stalls the output at random
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    action_t exp;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_actions.size() == 0) begin
          $display("%0t: unexpected action transfer: expected none, actual action %0d last %0d",
                   $realtime, out_if.action, out_if.last);
          n_errors++;
        end else begin
          exp = expected_actions.pop_front();
          n_checked++;
          if (exp.act == ACT_POSSIBLE) n_possible++;
          if (exp.act == ACT_IMPOSSIBLE) n_impossible++;
          if (out_if.action !== exp.act) begin
            $display("%0t: action mismatch: expected %0d (%s), actual %0d",
                     $realtime, exp.act, exp.act.name(), out_if.action);
            n_errors++;
          end
          if (out_if.last !== exp.last) begin
            $display("%0t: last mismatch: expected %0d, actual %0d",
                     $realtime, exp.last, out_if.last);
            n_errors++;
          end
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        out_if.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        snk_gap = $urandom_range(0, 18);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d items unsent and %0d actions outstanding",
               $realtime, pending_items.size(), expected_actions.size());
      $display("tb_stack_permutation_sequencer NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    int n_directed;
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.operation  = OP_LOAD;
    in_if.value      = '0;
    out_if.ready     = 1'b0;
    no_idle          = 1'b0;
    shadow_head      = 0;
    shadow_tail      = 0;
    shadow_depth     = 0;
    n_errors         = 0;
    n_queued         = 0;
    n_sent           = 0;
    n_checked        = 0;
    n_possible       = 0;
    n_impossible     = 0;
    n_overflow       = 0;
    src_gap          = 0;
    snk_gap          = 0;
    cycles           = 0;

    // finish on an empty block, ignored code, target with nothing to find
    queue_item(OP_FINISH, 16'h0000, 1'b0);
    queue_item(OP_UNUSED, 16'hFFFF, 1'b0);
    queue_item(OP_TARGET, 16'h1234, 1'b0);
    // extreme values: miss then match, stack top match, a miss that drains the queue
    queue_item(OP_LOAD, 16'h0000, 1'b0);
    queue_item(OP_LOAD, 16'hFFFF, 1'b0);
    queue_item(OP_LOAD, 16'h5A5A, 1'b0);
    queue_item(OP_TARGET, 16'hFFFF, 1'b0);
    queue_item(OP_TARGET, 16'h0000, 1'b0);
    queue_item(OP_TARGET, 16'hA5A5, 1'b0);
    queue_item(OP_TARGET, 16'hA5A5, 1'b0);  // queue empty, stack top does not match
    queue_item(OP_FINISH, 16'h0000, 1'b0);  // stack not empty
    // possible round, finish sent only once the output has drained
    queue_item(OP_LOAD, 16'h8001, 1'b0);
    queue_item(OP_LOAD, 16'h7FFE, 1'b0);
    queue_item(OP_TARGET, 16'h7FFE, 1'b0);
    queue_item(OP_TARGET, 16'h8001, 1'b0);
    queue_item(OP_FINISH, 16'hFFFF, 1'b1);
    // duplicate values
    queue_item(OP_LOAD, 16'h0003, 1'b0);
    queue_item(OP_LOAD, 16'h0003, 1'b0);
    queue_item(OP_TARGET, 16'h0003, 1'b0);
    queue_item(OP_TARGET, 16'h0003, 1'b0);
    queue_item(OP_FINISH, 16'h0000, 1'b0);
    // leftover in the queue does not spoil the verdict
    queue_item(OP_LOAD, 16'h0001, 1'b0);
    queue_item(OP_FINISH, 16'h0000, 1'b0);
    n_directed = n_queued;

    while (n_queued < n_directed + RANDOM_ITEMS) queue_round();
    queue_item(OP_FINISH, 16'h0000, 1'b0);
    calm_from = pending_items.size() - CALM_TAIL;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() > 0 || in_if.valid) @(posedge clk_i);
    while (expected_actions.size() > 0) @(posedge clk_i);
    // anything the block still emits now is caught by the monitor
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d items, checked %0d actions, %0d dropped loads",
             n_sent, n_checked, n_overflow);
    $display("verdicts seen: %0d possible, %0d not possible", n_possible, n_impossible);
    if (n_errors == 0) begin
      $display("tb_stack_permutation_sequencer OK");
    end else begin
      $display("tb_stack_permutation_sequencer NOT OK");
    end
    $finish;
  end

endmodule
